[design/rpast_pkg.sv]
`default_nettype none

package rpast_pkg;

    // Fixed field widths of the request and result channels.
    localparam int TYPE_W = 2;
    localparam int POS_W  = 17;
    localparam int VAL_W  = 32;
    localparam int SUM_W  = 64;
    localparam int STEP_W = 32;

    // Request kinds.
    localparam logic [TYPE_W-1:0] REQ_LOAD  = 2'd0;
    localparam logic [TYPE_W-1:0] REQ_PROG  = 2'd1;
    localparam logic [TYPE_W-1:0] REQ_QUERY = 2'd2;

    // Reset value of the element count register.
    localparam logic [POS_W-1:0] ELEM_RESET = 17'd65536;

    // Multiply steps of one tag fold.
    localparam logic [2:0] MS_TRI   = 3'd0;  // len * (len + 1)
    localparam logic [2:0] MS_BASEL = 3'd1;  // base low word * len
    localparam logic [2:0] MS_BASEH = 3'd2;  // base high word * len
    localparam logic [2:0] MS_STEPL = 3'd3;  // step * triangle low word
    localparam logic [2:0] MS_STEPH = 3'd4;  // step * triangle high word
    localparam logic [2:0] MS_HALF  = 3'd5;  // step * left child length

    typedef enum logic [15:0] {
        ST_CLEAR  = 16'h0001,
        ST_IDLE   = 16'h0002,
        ST_VISIT  = 16'h0004,
        ST_LOADN  = 16'h0008,
        ST_MUL    = 16'h0010,
        ST_ACC    = 16'h0020,
        ST_STW    = 16'h0040,
        ST_CH0    = 16'h0080,
        ST_CH1    = 16'h0100,
        ST_CH2    = 16'h0200,
        ST_DECIDE = 16'h0400,
        ST_RET    = 16'h0800,
        ST_CMB0   = 16'h1000,
        ST_CMB1   = 16'h2000,
        ST_CMB2   = 16'h4000,
        ST_DONE   = 16'h8000
    } state_t;

endpackage

`default_nettype wire

[design/rpast_ram.sv]
`default_nettype none

module rpast_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 1024,
    localparam int AW = $clog2(DEPTH)
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // One write port and one registered read port.
    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

[design/range_progression_add_sum_tree.sv]
// Each visited tree node is read, loaded, decided on and returned from; a pending tag on it is
// folded first (with fewer multiply steps at a leaf), a progression that lands on it is folded
// the same way, and on the way up a load or progression pops and recombines each parent. An
// item visits up to about four nodes per level; an ignored request takes no tree walk.
// Requests are taken one at a time, and the walk shares a single 32x32 multiplier. Reset: a
// clearing pass writes zero to all 4 * MAX_ELEMENTS entries of the node memories.
`default_nettype none

module range_progression_add_sum_tree #(
    parameter int MAX_ELEMENTS = 65536
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            cfg_wr_en,
    input  wire logic [rpast_pkg::POS_W-1:0]     cfg_wr_data,
    input  wire logic                            s_valid,
    output logic                                 s_ready,
    input  wire logic [rpast_pkg::TYPE_W-1:0]    s_req_type,
    input  wire logic [rpast_pkg::POS_W-1:0]     s_range_left,
    input  wire logic [rpast_pkg::POS_W-1:0]     s_range_right,
    input  wire logic signed [rpast_pkg::VAL_W-1:0] s_load_value,
    output logic                                 m_valid,
    input  wire logic                            m_ready,
    output logic signed [rpast_pkg::SUM_W-1:0]   m_range_sum
);

    // Node memories are zeroed before the first request is taken; the element count
    // resets to 65536.

    localparam int NODES = 4 * MAX_ELEMENTS;
    localparam int NW    = $clog2(NODES);
    localparam int PW    = $clog2(MAX_ELEMENTS + 1);
    localparam int CW    = (PW > rpast_pkg::POS_W) ? PW : rpast_pkg::POS_W;
    localparam int STK   = $clog2(MAX_ELEMENTS) + 1;
    localparam int SPW   = $clog2(STK);
    localparam int SPW1  = $clog2(STK + 1);
    localparam int SW    = rpast_pkg::SUM_W;
    localparam int TW    = rpast_pkg::STEP_W;

    rpast_pkg::state_t state_reg;

    logic [rpast_pkg::POS_W-1:0]  elem_reg;
    logic [NW-1:0]                clr_reg;
    logic [rpast_pkg::TYPE_W-1:0] op_reg;
    logic [rpast_pkg::POS_W-1:0]  a_reg;
    logic [rpast_pkg::POS_W-1:0]  b_reg;
    logic [SW-1:0]                val_reg;
    logic [NW-1:0]                nd_reg;
    logic [PW-1:0]                lo_reg;
    logic [PW-1:0]                hi_reg;
    logic [SW-1:0]                sum_reg;
    logic [SW-1:0]                tb_reg;
    logic [TW-1:0]                ts_reg;
    logic [SW-1:0]                acc_reg;
    logic [SW-1:0]                prod_reg;
    logic [SW-1:0]                tri_reg;
    logic [SW-1:0]                rbase_reg;
    logic [SW-1:0]                tmp_reg;
    logic [SW-1:0]                qacc_reg;
    logic [2:0]                   mstep_reg;
    logic                         sret_reg;
    logic [SPW1-1:0]              sp_reg;
    logic                         m_valid_reg;
    logic [SW-1:0]                m_sum_reg;

    // Stack of ancestor nodes on the way down.
    logic [NW-1:0] stk_nd [STK];
    logic [PW-1:0] stk_lo [STK];
    logic [PW-1:0] stk_hi [STK];
    logic          stk_ph [STK];

    // Memory ports.
    logic          sum_we,  base_we,  step_we;
    logic [NW-1:0] sum_wa,  base_wa,  step_wa;
    logic [SW-1:0] sum_wd,  base_wd;
    logic [TW-1:0] step_wd;
    logic [NW-1:0] sum_ra,  tag_ra;
    logic [SW-1:0] sum_rd,  base_rd;
    logic [TW-1:0] step_rd;

    // Working values.
    logic [CW-1:0] elem_ext;
    logic [PW-1:0] n_eff;
    logic [PW-1:0] len;
    logic [PW-1:0] half;
    logic [PW-1:0] mid;
    logic [NW-1:0] ch_l, ch_r;
    logic          is_leaf;
    logic [CW-1:0] a_ext, b_ext, lo_ext, hi_ext;
    logic          contained, disjoint, load_out;
    logic [TW-1:0] mul_a, mul_b;
    logic [SPW-1:0] sp_idx, top_idx;
    logic [PW-1:0] top_mid;
    logic          start_ok;

    assign s_ready     = (state_reg == rpast_pkg::ST_IDLE);
    assign m_valid     = m_valid_reg;
    assign m_range_sum = m_sum_reg;

    // Element count clamped to the supported range.
    always_comb begin
        elem_ext = CW'(elem_reg);
        if (elem_ext == '0) begin
            n_eff = PW'(1);
        end else if (elem_ext > CW'(MAX_ELEMENTS)) begin
            n_eff = PW'(MAX_ELEMENTS);
        end else begin
            n_eff = elem_ext[PW-1:0];
        end
    end

    // Geometry of the current node.
    assign len     = hi_reg - lo_reg + PW'(1);
    assign mid     = lo_reg + ((hi_reg - lo_reg) >> 1);
    assign half    = mid + PW'(1) - lo_reg;
    assign ch_l    = {nd_reg[NW-2:0], 1'b0};
    assign ch_r    = {nd_reg[NW-2:0], 1'b1};
    assign is_leaf = (lo_reg == hi_reg);

    // Range tests of the current node against the request.
    assign a_ext     = CW'(a_reg);
    assign b_ext     = CW'(b_reg);
    assign lo_ext    = CW'(lo_reg);
    assign hi_ext    = CW'(hi_reg);
    assign contained = (a_ext <= lo_ext) && (hi_ext <= b_ext);
    assign disjoint  = (hi_ext < a_ext) || (lo_ext > b_ext);
    assign load_out  = (a_ext < lo_ext) || (a_ext > hi_ext);

    assign sp_idx  = sp_reg[SPW-1:0];
    assign top_idx = SPW'(sp_reg - SPW1'(1));
    assign top_mid = stk_lo[top_idx] + ((stk_hi[top_idx] - stk_lo[top_idx]) >> 1);

    // Whether an accepted request needs a tree walk.
    always_comb begin
        case (s_req_type)
            rpast_pkg::REQ_LOAD: begin
                start_ok = (s_range_left != '0) && (CW'(s_range_left) <= CW'(n_eff));
            end
            rpast_pkg::REQ_PROG, rpast_pkg::REQ_QUERY: begin
                start_ok = (s_range_left <= s_range_right);
            end
            default: begin
                start_ok = 1'b0;
            end
        endcase
    end

    // Operand select for the shared multiplier.
    always_comb begin
        case (mstep_reg)
            rpast_pkg::MS_TRI: begin
                mul_a = TW'(len);
                mul_b = TW'(len) + TW'(1);
            end
            rpast_pkg::MS_BASEL: begin
                mul_a = tb_reg[31:0];
                mul_b = TW'(len);
            end
            rpast_pkg::MS_BASEH: begin
                mul_a = tb_reg[63:32];
                mul_b = TW'(len);
            end
            rpast_pkg::MS_STEPL: begin
                mul_a = ts_reg;
                mul_b = tri_reg[31:0];
            end
            rpast_pkg::MS_STEPH: begin
                mul_a = ts_reg;
                mul_b = tri_reg[63:32];
            end
            default: begin
                mul_a = ts_reg;
                mul_b = TW'(half);
            end
        endcase
    end

    // Memory port control.
    always_comb begin
        sum_we  = 1'b0;
        base_we = 1'b0;
        step_we = 1'b0;
        sum_wa  = nd_reg;
        base_wa = nd_reg;
        step_wa = nd_reg;
        sum_wd  = '0;
        base_wd = '0;
        step_wd = '0;
        sum_ra  = nd_reg;
        tag_ra  = nd_reg;
        case (state_reg)
            rpast_pkg::ST_CLEAR: begin
                sum_we  = 1'b1;
                base_we = 1'b1;
                step_we = 1'b1;
                sum_wa  = clr_reg;
                base_wa = clr_reg;
                step_wa = clr_reg;
            end
            rpast_pkg::ST_STW: begin
                sum_we  = 1'b1;
                base_we = 1'b1;
                step_we = 1'b1;
                sum_wd  = acc_reg;
            end
            rpast_pkg::ST_CH0: begin
                tag_ra = ch_l;
            end
            rpast_pkg::ST_CH1: begin
                tag_ra  = ch_r;
                base_we = 1'b1;
                step_we = 1'b1;
                base_wa = ch_l;
                step_wa = ch_l;
                base_wd = base_rd + tb_reg;
                step_wd = step_rd + ts_reg;
            end
            rpast_pkg::ST_CH2: begin
                base_we = 1'b1;
                step_we = 1'b1;
                base_wa = ch_r;
                step_wa = ch_r;
                base_wd = base_rd + rbase_reg;
                step_wd = step_rd + ts_reg;
            end
            rpast_pkg::ST_DECIDE: begin
                sum_we = (op_reg == rpast_pkg::REQ_LOAD) && !load_out && is_leaf;
                sum_wd = sum_reg + val_reg;
            end
            rpast_pkg::ST_CMB0: begin
                sum_ra = ch_l;
            end
            rpast_pkg::ST_CMB1: begin
                sum_ra = ch_r;
            end
            rpast_pkg::ST_CMB2: begin
                sum_we = 1'b1;
                sum_wd = tmp_reg + sum_rd;
            end
            default: begin
                sum_we = 1'b0;
            end
        endcase
    end

    rpast_ram #(.WIDTH(SW), .DEPTH(NODES)) u_sum_ram (
        .clk(aclk), .we(sum_we), .waddr(sum_wa), .wdata(sum_wd),
        .raddr(sum_ra), .rdata(sum_rd)
    );

    rpast_ram #(.WIDTH(SW), .DEPTH(NODES)) u_base_ram (
        .clk(aclk), .we(base_we), .waddr(base_wa), .wdata(base_wd),
        .raddr(tag_ra), .rdata(base_rd)
    );

    rpast_ram #(.WIDTH(TW), .DEPTH(NODES)) u_step_ram (
        .clk(aclk), .we(step_we), .waddr(step_wa), .wdata(step_wd),
        .raddr(tag_ra), .rdata(step_rd)
    );

    // Shared multiplier with a registered product.
    always_ff @(posedge aclk) begin
        prod_reg <= {32'b0, mul_a} * {32'b0, mul_b};
    end

    // Element count register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            elem_reg <= rpast_pkg::ELEM_RESET;
        end else if (cfg_wr_en) begin
            elem_reg <= cfg_wr_data;
        end
    end

    // Sequencer: clearing pass, tree walk, tag folding and result hand-off.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= rpast_pkg::ST_CLEAR;
            clr_reg     <= '0;
            sp_reg      <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (m_valid_reg && m_ready && state_reg != rpast_pkg::ST_DONE) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                rpast_pkg::ST_CLEAR: begin
                    clr_reg <= clr_reg + NW'(1);
                    if (clr_reg == NW'(NODES - 1)) begin
                        state_reg <= rpast_pkg::ST_IDLE;
                    end
                end
                rpast_pkg::ST_IDLE: begin
                    if (s_valid) begin
                        op_reg   <= s_req_type;
                        a_reg    <= s_range_left;
                        b_reg    <= s_range_right;
                        val_reg  <= SW'(s_load_value);
                        qacc_reg <= '0;
                        nd_reg   <= NW'(1);
                        lo_reg   <= PW'(1);
                        hi_reg   <= n_eff;
                        sp_reg   <= '0;
                        if (start_ok) begin
                            state_reg <= rpast_pkg::ST_VISIT;
                        end else if (s_req_type == rpast_pkg::REQ_QUERY) begin
                            state_reg <= rpast_pkg::ST_DONE;
                        end
                    end
                end
                rpast_pkg::ST_VISIT: begin
                    state_reg <= rpast_pkg::ST_LOADN;
                end
                rpast_pkg::ST_LOADN: begin
                    sum_reg   <= sum_rd;
                    tb_reg    <= base_rd;
                    ts_reg    <= step_rd;
                    acc_reg   <= sum_rd;
                    sret_reg  <= 1'b0;
                    mstep_reg <= rpast_pkg::MS_TRI;
                    if (base_rd == '0 && step_rd == '0) begin
                        state_reg <= rpast_pkg::ST_DECIDE;
                    end else begin
                        state_reg <= rpast_pkg::ST_MUL;
                    end
                end
                rpast_pkg::ST_MUL: begin
                    state_reg <= rpast_pkg::ST_ACC;
                end
                rpast_pkg::ST_ACC: begin
                    case (mstep_reg)
                        rpast_pkg::MS_TRI:   tri_reg <= prod_reg >> 1;
                        rpast_pkg::MS_BASEL: acc_reg <= acc_reg + prod_reg;
                        rpast_pkg::MS_BASEH: acc_reg <= acc_reg + {prod_reg[31:0], 32'b0};
                        rpast_pkg::MS_STEPL: acc_reg <= acc_reg + prod_reg;
                        rpast_pkg::MS_STEPH: acc_reg <= acc_reg + {prod_reg[31:0], 32'b0};
                        default:             rbase_reg <= tb_reg + prod_reg;
                    endcase
                    if (mstep_reg == rpast_pkg::MS_HALF ||
                        (mstep_reg == rpast_pkg::MS_STEPH && is_leaf)) begin
                        state_reg <= rpast_pkg::ST_STW;
                    end else begin
                        mstep_reg <= mstep_reg + 3'd1;
                        state_reg <= rpast_pkg::ST_MUL;
                    end
                end
                rpast_pkg::ST_STW: begin
                    sum_reg <= acc_reg;
                    if (!is_leaf) begin
                        state_reg <= rpast_pkg::ST_CH0;
                    end else if (sret_reg) begin
                        state_reg <= rpast_pkg::ST_RET;
                    end else begin
                        state_reg <= rpast_pkg::ST_DECIDE;
                    end
                end
                rpast_pkg::ST_CH0: begin
                    state_reg <= rpast_pkg::ST_CH1;
                end
                rpast_pkg::ST_CH1: begin
                    state_reg <= rpast_pkg::ST_CH2;
                end
                rpast_pkg::ST_CH2: begin
                    state_reg <= sret_reg ? rpast_pkg::ST_RET : rpast_pkg::ST_DECIDE;
                end
                rpast_pkg::ST_DECIDE: begin
                    // Push the current node; it is kept only when the walk goes down into the left child.
                    stk_nd[sp_idx] <= nd_reg;
                    stk_lo[sp_idx] <= lo_reg;
                    stk_hi[sp_idx] <= hi_reg;
                    stk_ph[sp_idx] <= 1'b0;
                    case (op_reg)
                        rpast_pkg::REQ_QUERY: begin
                            if (contained) begin
                                qacc_reg  <= qacc_reg + sum_reg;
                                state_reg <= rpast_pkg::ST_RET;
                            end else if (disjoint) begin
                                state_reg <= rpast_pkg::ST_RET;
                            end else begin
                                sp_reg    <= sp_reg + SPW1'(1);
                                nd_reg    <= ch_l;
                                hi_reg    <= mid;
                                state_reg <= rpast_pkg::ST_VISIT;
                            end
                        end
                        rpast_pkg::REQ_PROG: begin
                            if (contained) begin
                                // Fold a fresh progression tag into this node.
                                tb_reg    <= SW'(lo_reg) - SW'(a_reg);
                                ts_reg    <= TW'(1);
                                acc_reg   <= sum_reg;
                                sret_reg  <= 1'b1;
                                mstep_reg <= rpast_pkg::MS_TRI;
                                state_reg <= rpast_pkg::ST_MUL;
                            end else if (disjoint) begin
                                state_reg <= rpast_pkg::ST_RET;
                            end else begin
                                sp_reg    <= sp_reg + SPW1'(1);
                                nd_reg    <= ch_l;
                                hi_reg    <= mid;
                                state_reg <= rpast_pkg::ST_VISIT;
                            end
                        end
                        default: begin
                            if (load_out || is_leaf) begin
                                state_reg <= rpast_pkg::ST_RET;
                            end else begin
                                sp_reg    <= sp_reg + SPW1'(1);
                                nd_reg    <= ch_l;
                                hi_reg    <= mid;
                                state_reg <= rpast_pkg::ST_VISIT;
                            end
                        end
                    endcase
                end
                rpast_pkg::ST_RET: begin
                    if (sp_reg == '0) begin
                        state_reg <= (op_reg == rpast_pkg::REQ_QUERY) ?
                                     rpast_pkg::ST_DONE : rpast_pkg::ST_IDLE;
                    end else if (!stk_ph[top_idx]) begin
                        // Left subtree finished: walk the right one.
                        stk_ph[top_idx] <= 1'b1;
                        nd_reg    <= {stk_nd[top_idx][NW-2:0], 1'b1};
                        lo_reg    <= top_mid + PW'(1);
                        hi_reg    <= stk_hi[top_idx];
                        state_reg <= rpast_pkg::ST_VISIT;
                    end else begin
                        sp_reg <= sp_reg - SPW1'(1);
                        nd_reg <= stk_nd[top_idx];
                        lo_reg <= stk_lo[top_idx];
                        hi_reg <= stk_hi[top_idx];
                        if (op_reg != rpast_pkg::REQ_QUERY) begin
                            state_reg <= rpast_pkg::ST_CMB0;
                        end
                    end
                end
                rpast_pkg::ST_CMB0: begin
                    state_reg <= rpast_pkg::ST_CMB1;
                end
                rpast_pkg::ST_CMB1: begin
                    tmp_reg   <= sum_rd;
                    state_reg <= rpast_pkg::ST_CMB2;
                end
                rpast_pkg::ST_CMB2: begin
                    state_reg <= rpast_pkg::ST_RET;
                end
                rpast_pkg::ST_DONE: begin
                    if (!m_valid_reg || m_ready) begin
                        m_valid_reg <= 1'b1;
                        m_sum_reg   <= qacc_reg;
                        state_reg   <= rpast_pkg::ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= rpast_pkg::ST_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire
